// ===== hw/rtl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Types and constants shared by the circle/box contact pipeline.
// ----------------------------------------------------------------------------
package cbc_pkg;

    localparam int POS_W  = 24;
    localparam int EXT_W  = 23;
    localparam int NRM_W  = 16;
    localparam int MAG_W  = 25;
    localparam int SQ_W   = 51;
    localparam int LEN_W  = 26;
    localparam int QUO_W  = 15;
    localparam int NUM_W  = MAG_W + QUO_W + 1;
    localparam int SHF_W  = 5;

    localparam int ONE_Q14 = 16384;
    localparam int POS_MAX = 8388607;
    localparam int POS_MIN = -8388608;

    localparam int FRONT_STAGES = 8;
    localparam int SQRT_STAGES  = 26;
    localparam int DIV_STAGES   = 15;

    typedef struct packed {
        logic signed [POS_W-1:0] circle_x;
        logic signed [POS_W-1:0] circle_y;
        logic        [EXT_W-1:0] radius;
        logic signed [POS_W-1:0] box_x;
        logic signed [POS_W-1:0] box_y;
        logic        [EXT_W-1:0] half_w;
        logic        [EXT_W-1:0] half_h;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [POS_W-1:0] point_x;
        logic signed [POS_W-1:0] point_y;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
    } res_t;

    typedef struct packed {
        logic                    hit;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [NRM_W-1:0] nx_ax;
        logic signed [NRM_W-1:0] ny_ax;
        logic                    use_div;
        logic                    sx;
        logic                    sy;
        logic        [MAG_W-1:0] mx;
        logic        [MAG_W-1:0] my;
    } side_t;

endpackage

// ===== hw/rtl/cbc_isqrt.sv =====
// ----------------------------------------------------------------------------
// cbc_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cbc_isqrt (
    input  logic                       clk,
    input  logic                       en,
    input  logic [cbc_pkg::SQ_W-1:0]   n,
    output logic [cbc_pkg::LEN_W-1:0]  root
);
    import cbc_pkg::*;

    localparam int AW = SQ_W + 1;

    logic [AW-1:0] n_reg  [SQRT_STAGES];
    logic [AW-1:0] r_reg  [SQRT_STAGES];
    logic [AW-1:0] n_next [SQRT_STAGES];
    logic [AW-1:0] r_next [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++)
        begin : g_stg
            localparam logic [AW-1:0] BITV = AW'(1) << (2 * (SQRT_STAGES - 1 - k));
            logic [AW-1:0] n_in;
            logic [AW-1:0] r_in;
            logic [AW-1:0] sum;
            if (k == 0)
            begin : g_first
                assign n_in = {1'b0, n};
                assign r_in = '0;
            end
            else
            begin : g_rest
                assign n_in = n_reg[k-1];
                assign r_in = r_reg[k-1];
            end
            always_comb
            begin
                sum = r_in + BITV;
                if (n_in >= sum)
                begin
                    n_next[k] = n_in - sum;
                    r_next[k] = (r_in >> 1) + BITV;
                end
                else
                begin
                    n_next[k] = n_in;
                    r_next[k] = r_in >> 1;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SQRT_STAGES; i++)
            begin
                n_reg[i] <= n_next[i];
                r_reg[i] <= r_next[i];
            end
        end
    end

    assign root = r_reg[SQRT_STAGES-1][LEN_W-1:0];

endmodule

// ===== hw/rtl/cbc_div.sv =====
// ----------------------------------------------------------------------------
// cbc_div
// Pipelined restoring divider: round(m * 16384 / len), one quotient bit per stage.
// ----------------------------------------------------------------------------
module cbc_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [cbc_pkg::MAG_W-1:0]  m,
    input  logic [cbc_pkg::LEN_W-1:0]  len,
    output logic [cbc_pkg::QUO_W-1:0]  q
);
    import cbc_pkg::*;

    localparam int DW = LEN_W + 1;

    logic [NUM_W-1:0] rem_reg  [DIV_STAGES];
    logic [DW-1:0]    d_reg    [DIV_STAGES];
    logic [QUO_W-1:0] q_reg    [DIV_STAGES];
    logic [NUM_W-1:0] rem_next [DIV_STAGES];
    logic [DW-1:0]    d_next   [DIV_STAGES];
    logic [QUO_W-1:0] q_next   [DIV_STAGES];

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++)
        begin : g_stg
            logic [NUM_W-1:0] rem_in;
            logic [DW-1:0]    d_in;
            logic [QUO_W-1:0] q_in;
            logic [NUM_W-1:0] dsh;
            if (j == 0)
            begin : g_first
                assign rem_in = NUM_W'({m, QUO_W'(0)}) + NUM_W'(len);
                assign d_in   = {len, 1'b0};
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign d_in   = d_reg[j-1];
                assign q_in   = q_reg[j-1];
            end
            always_comb
            begin
                dsh       = NUM_W'(d_in) << (DIV_STAGES - 1 - j);
                d_next[j] = d_in;
                if (rem_in >= dsh)
                begin
                    rem_next[j] = rem_in - dsh;
                    q_next[j]   = {q_in[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j] = rem_in;
                    q_next[j]   = {q_in[QUO_W-2:0], 1'b0};
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                rem_reg[i] <= rem_next[i];
                d_reg[i]   <= d_next[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    assign q = q_reg[DIV_STAGES-1];

endmodule

// ===== hw/rtl/circle_box_contact.sv =====
// ----------------------------------------------------------------------------
// circle_box_contact
// Throughput: one request per cycle; a stalled result holds the whole pipeline.
// Depth includes the front stages, the 26-stage square root, the two parallel 15-stage dividers and the output stage.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
module circle_box_contact (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cbc_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_ready,
    output cbc_pkg::res_t res_data
);
    import cbc_pkg::*;

    localparam int NSTG = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;

    logic [NSTG-1:0] vld_reg;
    logic            adv;

    assign adv       = !vld_reg[NSTG-1] || res_ready;
    assign req_ready = adv;
    assign res_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], req_valid};
    end

    // stage 1: relative position and region
    logic signed [MAG_W-1:0] s1_rx_next, s1_ry_next, s1_rx_reg, s1_ry_reg;
    logic signed [MAG_W:0]   rx26, ry26, hw26, hh26;
    logic                    s1_xl_next, s1_xh_next, s1_yl_next, s1_yh_next;
    logic                    s1_xl_reg, s1_xh_reg, s1_yl_reg, s1_yh_reg;
    logic signed [POS_W-1:0] s1_bx_reg, s1_by_reg;
    logic        [EXT_W-1:0] s1_hw_reg, s1_hh_reg, s1_r_reg;

    always_comb
    begin
        s1_rx_next = $signed({req_data.circle_x[POS_W-1], req_data.circle_x})
                   - $signed({req_data.box_x[POS_W-1], req_data.box_x});
        s1_ry_next = $signed({req_data.circle_y[POS_W-1], req_data.circle_y})
                   - $signed({req_data.box_y[POS_W-1], req_data.box_y});
        rx26 = {s1_rx_next[MAG_W-1], s1_rx_next};
        ry26 = {s1_ry_next[MAG_W-1], s1_ry_next};
        hw26 = $signed({3'b000, req_data.half_w});
        hh26 = $signed({3'b000, req_data.half_h});
        s1_xl_next = rx26 <= -hw26;
        s1_xh_next = rx26 >= hw26;
        s1_yl_next = ry26 <= -hh26;
        s1_yh_next = ry26 >= hh26;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rx_reg <= s1_rx_next;
            s1_ry_reg <= s1_ry_next;
            s1_xl_reg <= s1_xl_next;
            s1_xh_reg <= s1_xh_next;
            s1_yl_reg <= s1_yl_next;
            s1_yh_reg <= s1_yh_next;
            s1_bx_reg <= req_data.box_x;
            s1_by_reg <= req_data.box_y;
            s1_hw_reg <= req_data.half_w;
            s1_hh_reg <= req_data.half_h;
            s1_r_reg  <= req_data.radius;
        end
    end

    // stage 2: closest point and offset
    logic signed [MAG_W:0] ox, oy, rxe, rye;
    logic signed [MAG_W:0] s2_px_next, s2_py_next, s2_dx_next, s2_dy_next;
    logic signed [MAG_W:0] s2_px_reg, s2_py_reg, s2_dx_reg, s2_dy_reg;
    logic                  s2_xl_reg, s2_xh_reg, s2_yl_reg, s2_yh_reg;
    logic [EXT_W-1:0]      s2_r_reg;

    always_comb
    begin
        rxe = {s1_rx_reg[MAG_W-1], s1_rx_reg};
        rye = {s1_ry_reg[MAG_W-1], s1_ry_reg};
        if (s1_xl_reg)
            ox = -$signed({3'b000, s1_hw_reg});
        else if (s1_xh_reg)
            ox = $signed({3'b000, s1_hw_reg});
        else
            ox = rxe;
        if (s1_yl_reg)
            oy = -$signed({3'b000, s1_hh_reg});
        else if (s1_yh_reg)
            oy = $signed({3'b000, s1_hh_reg});
        else
            oy = rye;
        s2_px_next = $signed({{2{s1_bx_reg[POS_W-1]}}, s1_bx_reg}) + ox;
        s2_py_next = $signed({{2{s1_by_reg[POS_W-1]}}, s1_by_reg}) + oy;
        s2_dx_next = rxe - ox;
        s2_dy_next = rye - oy;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_px_reg <= s2_px_next;
            s2_py_reg <= s2_py_next;
            s2_dx_reg <= s2_dx_next;
            s2_dy_reg <= s2_dy_next;
            s2_xl_reg <= s1_xl_reg;
            s2_xh_reg <= s1_xh_reg;
            s2_yl_reg <= s1_yl_reg;
            s2_yh_reg <= s1_yh_reg;
            s2_r_reg  <= s1_r_reg;
        end
    end

    // stage 3: squares
    logic [MAG_W-1:0]     s3_mx_next, s3_my_next, s3_mx_reg, s3_my_reg;
    logic [2*MAG_W-1:0]   s3_dxx_reg, s3_dyy_reg;
    logic [2*EXT_W-1:0]   s3_r2_reg;
    logic                 s3_sx_reg, s3_sy_reg;
    logic signed [MAG_W:0] s3_px_reg, s3_py_reg;
    logic                 s3_xl_reg, s3_xh_reg, s3_yl_reg, s3_yh_reg;

    always_comb
    begin
        s3_mx_next = s2_dx_reg[MAG_W] ? MAG_W'(-s2_dx_reg) : MAG_W'(s2_dx_reg);
        s3_my_next = s2_dy_reg[MAG_W] ? MAG_W'(-s2_dy_reg) : MAG_W'(s2_dy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_mx_reg  <= s3_mx_next;
            s3_my_reg  <= s3_my_next;
            s3_dxx_reg <= s3_mx_next * s3_mx_next;
            s3_dyy_reg <= s3_my_next * s3_my_next;
            s3_r2_reg  <= s2_r_reg * s2_r_reg;
            s3_sx_reg  <= s2_dx_reg[MAG_W];
            s3_sy_reg  <= s2_dy_reg[MAG_W];
            s3_px_reg  <= s2_px_reg;
            s3_py_reg  <= s2_py_reg;
            s3_xl_reg  <= s2_xl_reg;
            s3_xh_reg  <= s2_xh_reg;
            s3_yl_reg  <= s2_yl_reg;
            s3_yh_reg  <= s2_yh_reg;
        end
    end

    // stage 4: hit test, saturation, axis normals
    side_t            s4_side_next, s4_side_reg;
    logic [MAG_W-1:0] s4_mm_next, s4_mm_reg;
    logic             xr, yr;

    always_comb
    begin
        xr = s3_xl_reg || s3_xh_reg;
        yr = s3_yl_reg || s3_yh_reg;
        s4_side_next.hit = ({1'b0, s3_dxx_reg} + {1'b0, s3_dyy_reg}) < SQ_W'(s3_r2_reg);
        if (s3_px_reg > (MAG_W+1)'(POS_MAX))
            s4_side_next.px = POS_W'(POS_MAX);
        else if (s3_px_reg < (MAG_W+1)'(POS_MIN))
            s4_side_next.px = POS_W'(POS_MIN);
        else
            s4_side_next.px = POS_W'(s3_px_reg);
        if (s3_py_reg > (MAG_W+1)'(POS_MAX))
            s4_side_next.py = POS_W'(POS_MAX);
        else if (s3_py_reg < (MAG_W+1)'(POS_MIN))
            s4_side_next.py = POS_W'(POS_MIN);
        else
            s4_side_next.py = POS_W'(s3_py_reg);
        s4_side_next.nx_ax = '0;
        s4_side_next.ny_ax = '0;
        if (s4_side_next.hit && !(xr && yr))
        begin
            if (xr)
                s4_side_next.nx_ax = s3_xl_reg ? -NRM_W'(ONE_Q14) : NRM_W'(ONE_Q14);
            else if (yr)
                s4_side_next.ny_ax = s3_yl_reg ? -NRM_W'(ONE_Q14) : NRM_W'(ONE_Q14);
            else
                s4_side_next.nx_ax = NRM_W'(ONE_Q14);
        end
        s4_side_next.use_div = s4_side_next.hit && xr && yr
                             && ((s3_mx_reg | s3_my_reg) != '0);
        s4_side_next.sx = s3_sx_reg;
        s4_side_next.sy = s3_sy_reg;
        s4_side_next.mx = s3_mx_reg;
        s4_side_next.my = s3_my_reg;
        s4_mm_next = (s3_mx_reg > s3_my_reg) ? s3_mx_reg : s3_my_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg <= s4_side_next;
            s4_mm_reg   <= s4_mm_next;
        end
    end

    // stage 5: normalizing shift amount
    logic [SHF_W-1:0] s5_sh_next, s5_sh_reg;
    side_t            s5_side_reg;

    always_comb
    begin
        s5_sh_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (s4_mm_reg[i])
                s5_sh_next = SHF_W'(MAG_W - 1 - i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_sh_reg   <= s5_sh_next;
            s5_side_reg <= s4_side_reg;
        end
    end

    // stage 6: shift
    side_t s6_side_next, s6_side_reg;

    always_comb
    begin
        s6_side_next    = s5_side_reg;
        s6_side_next.mx = s5_side_reg.mx << s5_sh_reg;
        s6_side_next.my = s5_side_reg.my << s5_sh_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s6_side_reg <= s6_side_next;
    end

    // stage 7: component squares
    logic [2*MAG_W-1:0] s7_sqx_reg, s7_sqy_reg;
    side_t              s7_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_sqx_reg  <= s6_side_reg.mx * s6_side_reg.mx;
            s7_sqy_reg  <= s6_side_reg.my * s6_side_reg.my;
            s7_side_reg <= s6_side_reg;
        end
    end

    // stage 8: length squared
    logic [SQ_W-1:0] s8_sum_reg;
    side_t           s8_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_sum_reg  <= {1'b0, s7_sqx_reg} + {1'b0, s7_sqy_reg};
            s8_side_reg <= s7_side_reg;
        end
    end

    // square root
    logic [LEN_W-1:0] len;
    side_t            sq_side_reg [SQRT_STAGES];

    cbc_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .n    (s8_sum_reg),
        .root (len)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= s8_side_reg;
            for (int i = 1; i < SQRT_STAGES; i++)
                sq_side_reg[i] <= sq_side_reg[i-1];
        end
    end

    // divide
    logic [QUO_W-1:0] qx, qy;
    side_t            dv_side_reg [DIV_STAGES];

    cbc_div u_div_x (
        .clk (clk),
        .en  (adv),
        .m   (sq_side_reg[SQRT_STAGES-1].mx),
        .len (len),
        .q   (qx)
    );

    cbc_div u_div_y (
        .clk (clk),
        .en  (adv),
        .m   (sq_side_reg[SQRT_STAGES-1].my),
        .len (len),
        .q   (qy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_side_reg[0] <= sq_side_reg[SQRT_STAGES-1];
            for (int i = 1; i < DIV_STAGES; i++)
                dv_side_reg[i] <= dv_side_reg[i-1];
        end
    end

    // output
    side_t            fin;
    logic [NRM_W-1:0] magx, magy;
    res_t             res_next, res_reg;

    always_comb
    begin
        fin  = dv_side_reg[DIV_STAGES-1];
        magx = (qx > QUO_W'(ONE_Q14)) ? NRM_W'(ONE_Q14) : NRM_W'(qx);
        magy = (qy > QUO_W'(ONE_Q14)) ? NRM_W'(ONE_Q14) : NRM_W'(qy);
        res_next.hit     = fin.hit;
        res_next.point_x = fin.px;
        res_next.point_y = fin.py;
        if (fin.use_div)
        begin
            res_next.normal_x = fin.sx ? -magx : magx;
            res_next.normal_y = fin.sy ? -magy : magy;
        end
        else
        begin
            res_next.normal_x = fin.nx_ax;
            res_next.normal_y = fin.ny_ax;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign res_data = res_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.hit |-> res_data.normal_x == '0 && res_data.normal_y == '0)
        else $error("normal nonzero on miss");

    a_nx_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.normal_x <= NRM_W'(ONE_Q14)
                   && res_data.normal_x >= -NRM_W'(ONE_Q14))
        else $error("normal_x out of range");

    a_ny_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.normal_y <= NRM_W'(ONE_Q14)
                   && res_data.normal_y >= -NRM_W'(ONE_Q14))
        else $error("normal_y out of range");

endmodule

// ===== test/tb_circle_box_contact.sv =====
// ----------------------------------------------------------------------------
// tb_circle_box_contact
// Checks the circle/box contact pipeline against a bit-exact predictor of the
// region choice, closest point, hit test and normalized contact normal, using
// directed corner cases, random geometry and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_circle_box_contact;
    import cbc_pkg::*;

    localparam int PIPE_DEPTH = 50;
    localparam int N_RANDOM   = 1200;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req_data;
    logic  res_valid;
    logic  res_ready;
    res_t  res_data;

    int    n_errors;
    int    send_idle_pct;
    int    recv_idle_pct;
    bit    hold_off;

    circle_box_contact dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned acc;
        longint unsigned bitv;
        acc  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= acc + bitv)
            begin
                n   -= acc + bitv;
                acc  = (acc >> 1) + bitv;
            end
            else
                acc >>= 1;
            bitv >>= 2;
        end
        return acc;
    endfunction

    function automatic logic signed [NRM_W-1:0] unit_comp(input longint unsigned m,
                                                          input bit neg,
                                                          input longint unsigned len);
        longint unsigned q;
        q = (m * (2 * ONE_Q14) + len) / (2 * len);
        if (q > ONE_Q14)
            q = ONE_Q14;
        return neg ? -$signed(q[NRM_W-1:0]) : $signed(q[NRM_W-1:0]);
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < POS_MIN)
            return POS_MIN;
        return v;
    endfunction

    function automatic res_t predict_contact(input req_t rq);
        res_t            rs;
        longint          cx, cy, bx, by, hw, hh, r, rx, ry, ox, oy, px, py, dx, dy;
        longint unsigned d2, r2, mx, my, mm, len;
        int              xr, yr;
        cx = longint'(rq.circle_x);
        cy = longint'(rq.circle_y);
        bx = longint'(rq.box_x);
        by = longint'(rq.box_y);
        hw = longint'(rq.half_w);
        hh = longint'(rq.half_h);
        r  = longint'(rq.radius);
        rx = cx - bx;
        ry = cy - by;
        xr = (rx <= -hw) ? -1 : ((rx >= hw) ? 1 : 0);
        yr = (ry <= -hh) ? -1 : ((ry >= hh) ? 1 : 0);
        ox = xr < 0 ? -hw : (xr > 0 ? hw : rx);
        oy = yr < 0 ? -hh : (yr > 0 ? hh : ry);
        px = bx + ox;
        py = by + oy;
        dx = cx - px;
        dy = cy - py;
        d2 = dx * dx + dy * dy;
        r2 = r * r;
        rs = '0;
        rs.hit     = d2 < r2;
        rs.point_x = POS_W'(clamp_pos(px));
        rs.point_y = POS_W'(clamp_pos(py));
        if (rs.hit)
        begin
            if (xr != 0 && yr != 0)
            begin
                mx = dx < 0 ? -dx : dx;
                my = dy < 0 ? -dy : dy;
                mm = mx > my ? mx : my;
                if (mm != 0)
                begin
                    while (mm < (64'd1 << 24))
                    begin
                        mm <<= 1;
                        mx <<= 1;
                        my <<= 1;
                    end
                    len = int_sqrt(mx * mx + my * my);
                    rs.normal_x = unit_comp(mx, dx < 0, len);
                    rs.normal_y = unit_comp(my, dy < 0, len);
                end
            end
            else if (xr != 0)
                rs.normal_x = NRM_W'(xr * ONE_Q14);
            else if (yr != 0)
                rs.normal_y = NRM_W'(yr * ONE_Q14);
            else
                rs.normal_x = NRM_W'(ONE_Q14);
        end
        return rs;
    endfunction

    class contact_board;
        res_t pending[$];

        function void note_request(input req_t rq);
            pending.push_back(predict_contact(rq));
        endfunction

        task check_result(input res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit)
                report("hit", longint'(got.hit), longint'(want.hit));
            if (got.point_x !== want.point_x)
                report("point_x", longint'(got.point_x), longint'(want.point_x));
            if (got.point_y !== want.point_y)
                report("point_y", longint'(got.point_y), longint'(want.point_y));
            if (got.normal_x !== want.normal_x)
                report("normal_x", longint'(got.normal_x), longint'(want.normal_x));
            if (got.normal_y !== want.normal_y)
                report("normal_y", longint'(got.normal_y), longint'(want.normal_y));
        endtask
    endclass

    contact_board board;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (req_valid && req_ready)
            board.note_request(req_data);
        if (res_valid && res_ready)
            board.check_result(res_data);
    end

    always @(negedge clk)
    begin
        if (hold_off)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(input req_t rq);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        req_valid = 1'b1;
        req_data  = rq;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic drain;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos;
        case ($urandom_range(3))
            0: return $urandom_range(1) ? POS_W'(POS_MAX) : POS_W'(POS_MIN);
            1: return POS_W'($signed(24'($urandom_range(4095))) - 2048);
            default: return $signed(24'($urandom));
        endcase
    endfunction

    function automatic logic [EXT_W-1:0] rand_ext;
        case ($urandom_range(4))
            0: return '0;
            1: return 23'h7fffff;
            2: return EXT_W'($urandom_range(2048));
            default: return 23'($urandom);
        endcase
    endfunction

    function automatic req_t random_request;
        req_t rq;
        int   mode;
        mode = $urandom_range(9);
        rq.box_x  = rand_pos();
        rq.box_y  = rand_pos();
        rq.half_w = rand_ext();
        rq.half_h = rand_ext();
        rq.radius = rand_ext();
        if (mode < 6)
        begin
            // near the box so hits and all nine regions occur
            rq.half_w   = EXT_W'($urandom_range(mode < 3 ? 4096 : 1 << 20));
            rq.half_h   = EXT_W'($urandom_range(mode < 3 ? 4096 : 1 << 20));
            rq.circle_x = POS_W'(rq.box_x + $signed(24'($urandom_range(2 * rq.half_w + 8192)))
                          - $signed(24'(rq.half_w)) - 4096);
            rq.circle_y = POS_W'(rq.box_y + $signed(24'($urandom_range(2 * rq.half_h + 8192)))
                          - $signed(24'(rq.half_h)) - 4096);
            rq.radius   = EXT_W'($urandom_range(mode < 3 ? 8192 : 1 << 21));
        end
        else
        begin
            rq.circle_x = rand_pos();
            rq.circle_y = rand_pos();
        end
        return rq;
    endfunction

    task automatic run_random(input int count);
        repeat (count)
            send_request(random_request());
    endtask

    task automatic run_directed;
        req_t rq;
        int   sx, sy;
        rq = '0;
        send_request(rq);
        rq = '{circle_x: 0, circle_y: 0, radius: 100, box_x: 0, box_y: 0, half_w: 0, half_h: 0};
        send_request(rq);
        for (sx = -1; sx <= 1; sx++)
            for (sy = -1; sy <= 1; sy++)
            begin
                rq = '{circle_x: POS_W'(1000 + sx * 600), circle_y: POS_W'(-500 + sy * 700),
                       radius: 400, box_x: 1000, box_y: -500, half_w: 500, half_h: 600};
                send_request(rq);
            end
        rq = '{circle_x: 1500, circle_y: 100, radius: 10, box_x: 1000, box_y: -500,
               half_w: 500, half_h: 600};
        send_request(rq);
        rq = '{circle_x: 1500, circle_y: 100, radius: 0, box_x: 1000, box_y: -500,
               half_w: 500, half_h: 600};
        send_request(rq);
        rq = '{circle_x: 1510, circle_y: 100, radius: 10, box_x: 1000, box_y: 0,
               half_w: 500, half_h: 100};
        send_request(rq);
        rq = '{circle_x: POS_W'(POS_MAX), circle_y: POS_W'(POS_MIN), radius: 23'h7fffff,
               box_x: POS_W'(POS_MAX), box_y: POS_W'(POS_MIN), half_w: 23'h7fffff,
               half_h: 23'h7fffff};
        send_request(rq);
        rq = '{circle_x: POS_W'(POS_MIN), circle_y: POS_W'(POS_MAX), radius: 23'h7fffff,
               box_x: POS_W'(POS_MIN), box_y: POS_W'(POS_MAX), half_w: 23'h7fffff,
               half_h: 23'h7fffff};
        send_request(rq);
        rq = '{circle_x: POS_W'(POS_MIN), circle_y: POS_W'(POS_MIN), radius: 23'h7fffff,
               box_x: POS_W'(POS_MAX), box_y: POS_W'(POS_MAX), half_w: 1, half_h: 1};
        send_request(rq);
        rq = '{circle_x: 3, circle_y: 2, radius: 5, box_x: 0, box_y: 0, half_w: 1, half_h: 1};
        send_request(rq);
        rq = '{circle_x: -24'sd1, circle_y: -24'sd1, radius: 23'h7fffff, box_x: -24'sd1,
               box_y: -24'sd1, half_w: 0, half_h: 0};
        send_request(rq);
    endtask

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        board         = new();
        n_errors      = 0;
        hold_off      = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 48;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_data      = '0;
        res_ready     = 1'b0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        drain();
        run_random(N_RANDOM / 3);
        // long receiver stall while requests keep coming
        fork
        begin
            hold_off = 1'b1;
            repeat (300)
                @(negedge clk);
            hold_off = 1'b0;
        end
        run_random(100);
        join
        drain();
        send_idle_pct = 48;
        recv_idle_pct = 37;
        run_random(N_RANDOM / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(N_RANDOM / 3);
        drain();
        repeat (PIPE_DEPTH + 10)
            @(negedge clk);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
